/* hdl/ppt_pkg.sv */
// Package: shared constants, codes and word types of the pen proximity timeout tracker.
package ppt_pkg;

  localparam int TIME_BITS    = 48;
  localparam int TIMEOUT_BITS = 20;
  localparam int BTN_BITS     = 4;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(50 * 1000);

  typedef enum logic [0:0] {
    OP_EVENT = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_OTHER      = 2'd0,
    KIND_BUTTON     = 2'd1,
    KIND_PEN        = 2'd2,
    KIND_OTHER_TOOL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VAL_RELEASE = 2'd0,
    VAL_PRESS   = 2'd1,
    VAL_REPEAT  = 2'd2
  } value_t;

  typedef enum logic [1:0] {
    ACT_PROX_OUT = 2'd0,
    ACT_PROX_IN  = 2'd1,
    ACT_STOPPED  = 2'd2
  } action_t;

  // classified word passed from front to back
  typedef struct packed {
    logic                  is_check;
    logic [TIME_BITS-1:0]  time_us;
    logic [TIME_BITS-1:0]  time_plus;   // time_us + timeout, saturated
    logic [TIME_BITS-1:0]  time_minus;  // time_us - timeout, floored at zero
    kind_t                 kind;
    logic [BTN_BITS-1:0]   btn_mask;
    logic                  btn_set;
    logic                  pen_val;
    logic                  last;
  } cmd_t;

endpackage

/* hdl/ppt_ifs.sv */
// Interfaces: event, result and configuration channels.
interface ppt_evt_if import ppt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [TIME_BITS-1:0] time_us;
  logic [1:0]           event_kind;
  logic [1:0]           button_index;
  logic [1:0]           event_value;
  logic                 last_in_frame;

  modport source (output valid, operation, time_us, event_kind, button_index,
                  event_value, last_in_frame, input ready);
  modport sink (input valid, operation, time_us, event_kind, button_index,
                event_value, last_in_frame, output ready);
endinterface

interface ppt_res_if import ppt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [TIME_BITS-1:0] action_time_us;

  modport source (output valid, action, action_time_us, input ready);
  modport sink (input valid, action, action_time_us, output ready);
endinterface

interface ppt_cfg_if import ppt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TIMEOUT_BITS-1:0] timeout_us;

  modport source (output valid, timeout_us, input ready);
  modport sink (input valid, timeout_us, output ready);
endinterface

/* hdl/pen_proximity_timeout_tracker_top.sv */
// Top level: pen proximity timeout tracker.
//
// evt carries one word per frame event or timer check (operation, time_us,
// event kind, button index, value, last-of-frame flag). res carries at most
// one word per input word: forced proximity-out, proximity-in or tracking
// stopped, with its timestamp. cfg writes the 20-bit timeout in us; write it
// only while no words are in flight.
// The front classifies each word and precomputes time +/- timeout into a
// four-deep queue; the back updates the tracker state from the queue head.
// Throughput is one word per cycle unless res stalls. An accepted word is
// queued and popped by the back; its result is driven on res from an output
// register. When res stalls the back holds; the queue absorbs up to four
// words before evt.ready drops. Reset (rst, synchronous) empties the queue,
// clears res.valid, restores the 50000 us timeout and re-enables tracking.
module pen_proximity_timeout_tracker_top import ppt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ppt_evt_if.sink    evt,
  ppt_cfg_if.sink    cfg,
  ppt_res_if.source  res
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t pop_cmd;
  logic [TIMEOUT_BITS-1:0] timeout_us;

  ppt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .timeout_us (timeout_us)
  );

  ppt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ppt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .cmd        (pop_cmd),
    .timeout_us (timeout_us),
    .pop        (pop),
    .res        (res)
  );

endmodule

/* hdl/ppt_front.sv */
// Front end: timeout register, event word accept and classification.
module ppt_front import ppt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  ppt_evt_if.sink                 evt,
  ppt_cfg_if.sink                 cfg,
  input  logic                    q_full,
  output logic                    push,
  output cmd_t                    push_cmd,
  output logic [TIMEOUT_BITS-1:0] timeout_us
);

  logic [TIME_BITS:0]      sum;
  logic [TIME_BITS-1:0]    tmo_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      timeout_us <= cfg.timeout_us;
    end
  end

  assign evt.ready = !q_full;
  assign push      = evt.valid && !q_full;

  assign tmo_ext = TIME_BITS'(timeout_us);
  assign sum     = {1'b0, evt.time_us} + {1'b0, tmo_ext};

  always_comb begin
    push_cmd            = '0;
    push_cmd.is_check   = (op_t'(evt.operation) == OP_CHECK);
    push_cmd.time_us    = evt.time_us;
    push_cmd.time_plus  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    push_cmd.time_minus = (evt.time_us > tmo_ext) ? (evt.time_us - tmo_ext) : '0;
    push_cmd.kind       = kind_t'(evt.event_kind);
    push_cmd.btn_mask   = BTN_BITS'(1) << evt.button_index;
    push_cmd.btn_set    = (value_t'(evt.event_value) != VAL_RELEASE);
    push_cmd.pen_val    = (value_t'(evt.event_value) == VAL_PRESS);
    push_cmd.last       = evt.last_in_frame;
  end

endmodule

/* hdl/ppt_queue.sv */
// Short FIFO of classified words between front and back.
module ppt_queue import ppt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full    = (count == (QPTR_BITS+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/ppt_back.sv */
// Back end: tracker state update and registered result word.
module ppt_back import ppt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  cmd_t                    cmd,
  input  logic [TIMEOUT_BITS-1:0] timeout_us,
  output logic                    pop,
  ppt_res_if.source               res
);

  logic [TIME_BITS-1:0] last_seen, last_seen_next;
  logic [TIME_BITS:0]   last_sum;
  logic [TIME_BITS-1:0] last_plus;
  logic [TIME_BITS-1:0] deadline, deadline_next;
  logic                 armed, armed_next;
  logic [BTN_BITS-1:0]  held, held_next;
  logic                 pen_in, pen_in_next;
  logic                 forced_out, forced_out_next;
  logic                 pen_seen, pen_seen_next;
  logic                 active, active_next;
  logic                 emit;
  action_t              emit_act;

  logic                 res_valid;
  action_t              res_action;
  logic [TIME_BITS-1:0] res_time;

  assign pop = !q_empty && (!res_valid || res.ready);

  // last event time + timeout, saturated
  assign last_sum  = {1'b0, last_seen} + {1'b0, TIME_BITS'(timeout_us)};
  assign last_plus = last_sum[TIME_BITS] ? '1 : last_sum[TIME_BITS-1:0];

  always_comb begin
    last_seen_next  = last_seen;
    deadline_next   = deadline;
    armed_next      = armed;
    held_next       = held;
    pen_in_next     = pen_in;
    forced_out_next = forced_out;
    pen_seen_next   = pen_seen;
    active_next     = active;
    emit            = 1'b0;
    emit_act        = ACT_PROX_OUT;
    if (pop && active) begin
      if (cmd.is_check) begin
        if (armed && (cmd.time_us >= deadline)) begin
          if (held != '0) begin
            deadline_next = cmd.time_plus;
          end else if (last_seen > cmd.time_minus) begin
            deadline_next = last_plus;
          end else begin
            armed_next      = 1'b0;
            forced_out_next = 1'b1;
            emit            = 1'b1;
            emit_act        = ACT_PROX_OUT;
          end
        end
      end else begin
        if (last_seen == '0) begin
          deadline_next = cmd.time_plus;
          armed_next    = 1'b1;
        end
        last_seen_next = cmd.time_us;
        case (cmd.kind)
          KIND_BUTTON: begin
            held_next = cmd.btn_set ? (held | cmd.btn_mask) : (held & ~cmd.btn_mask);
          end
          KIND_PEN: begin
            pen_seen_next = 1'b1;
            pen_in_next   = cmd.pen_val;
          end
          default: begin
          end
        endcase
        if (cmd.kind == KIND_OTHER_TOOL) begin
          active_next   = 1'b0;
          armed_next    = 1'b0;
          pen_seen_next = 1'b0;
          emit          = 1'b1;
          emit_act      = ACT_STOPPED;
        end else if (cmd.last) begin
          if (pen_seen_next) begin
            pen_seen_next = 1'b0;
            if (pen_in_next) begin
              deadline_next = cmd.time_plus;
              armed_next    = 1'b1;
            end else begin
              active_next = 1'b0;
              armed_next  = 1'b0;
              emit        = 1'b1;
              emit_act    = ACT_STOPPED;
            end
          end else if (forced_out) begin
            forced_out_next = 1'b0;
            deadline_next   = cmd.time_plus;
            armed_next      = 1'b1;
            emit            = 1'b1;
            emit_act        = ACT_PROX_IN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen  <= '0;
      deadline   <= '0;
      armed      <= 1'b0;
      held       <= '0;
      pen_in     <= 1'b0;
      forced_out <= 1'b0;
      pen_seen   <= 1'b0;
      active     <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      last_seen  <= last_seen_next;
      deadline   <= deadline_next;
      armed      <= armed_next;
      held       <= held_next;
      pen_in     <= pen_in_next;
      forced_out <= forced_out_next;
      pen_seen   <= pen_seen_next;
      active     <= active_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit) begin
      res_action <= emit_act;
      res_time   <= cmd.time_us;
    end
  end

  assign res.valid          = res_valid;
  assign res.action         = res_action;
  assign res.action_time_us = res_time;

endmodule

/* dv/tb.sv */
// Testbench: randomized event/check stimulus with a state predictor for the proximity tracker.
module tb;
  import ppt_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef struct {
    op_t                  op;
    logic [TIME_BITS-1:0] t;
    kind_t                kind;
    logic [1:0]           bidx;
    value_t               val;
    logic                 last;
  } evt_word_t;

  typedef struct {
    action_t              act;
    logic [TIME_BITS-1:0] ts;
  } prox_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppt_evt_if evt_bus ();
  ppt_cfg_if cfg_bus ();
  ppt_res_if res_bus ();

  pen_proximity_timeout_tracker_top dut (
    .clk (clk),
    .rst (rst),
    .evt (evt_bus),
    .cfg (cfg_bus),
    .res (res_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracker state as predicted
  logic [TIMEOUT_BITS-1:0] trk_timeout   = TIMEOUT_RESET;
  logic [TIME_BITS-1:0]    trk_last_seen = '0;
  logic [TIME_BITS-1:0]    trk_deadline  = '0;
  logic                    trk_armed     = 1'b0;
  logic [BTN_BITS-1:0]     trk_buttons   = '0;
  logic                    trk_pen_in    = 1'b0;
  logic                    trk_forced    = 1'b0;
  logic                    trk_pen_seen  = 1'b0;
  logic                    trk_active    = 1'b1;

  prox_result_t due_actions[$];
  evt_word_t    evt_backlog[$];

  int           err_count = 0;
  int           gap_left;
  int           burst_left;
  int           gap_max = 0;
  bit           res_steady = 1'b0;
  bit           res_hold = 1'b0;
  bit           press_go = 1'b0;
  logic [4:0]   stall_cnt;
  int           stall_len;
  evt_word_t    live_word;
  evt_word_t    next_word;
  prox_result_t got_word;
  logic [TIME_BITS-1:0] clock_us;

  task automatic flag_mismatch(input string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [TIME_BITS-1:0] expiry_of(input logic [TIME_BITS-1:0] t);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + (TIME_BITS+1)'(trk_timeout);
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  task automatic expect_action(input action_t act, input logic [TIME_BITS-1:0] t);
    prox_result_t r;
    r.act = act;
    r.ts  = t;
    due_actions.push_back(r);
  endtask

  task automatic track_word(input evt_word_t w);
    logic [TIME_BITS-1:0] floor_t;
    if (!trk_active) return;
    if (w.op == OP_CHECK) begin
      if (!trk_armed || w.t < trk_deadline) return;
      if (trk_buttons != '0) begin
        trk_deadline = expiry_of(w.t);
        return;
      end
      floor_t = (w.t > TIME_BITS'(trk_timeout)) ? w.t - TIME_BITS'(trk_timeout) : '0;
      if (trk_last_seen > floor_t) begin
        trk_deadline = expiry_of(trk_last_seen);
        return;
      end
      trk_armed  = 1'b0;
      trk_forced = 1'b1;
      expect_action(ACT_PROX_OUT, w.t);
      return;
    end
    if (trk_last_seen == '0) begin
      trk_deadline = expiry_of(w.t);
      trk_armed    = 1'b1;
    end
    trk_last_seen = w.t;
    case (w.kind)
      KIND_BUTTON: trk_buttons[w.bidx] = (w.val != VAL_RELEASE);
      KIND_PEN: begin
        trk_pen_seen = 1'b1;
        trk_pen_in   = (w.val == VAL_PRESS);
      end
      KIND_OTHER_TOOL: begin
        trk_active   = 1'b0;
        trk_armed    = 1'b0;
        trk_pen_seen = 1'b0;
        expect_action(ACT_STOPPED, w.t);
        return;
      end
      default: ;
    endcase
    if (!w.last) return;
    if (trk_pen_seen) begin
      trk_pen_seen = 1'b0;
      if (trk_pen_in) begin
        trk_deadline = expiry_of(w.t);
        trk_armed    = 1'b1;
      end else begin
        trk_active = 1'b0;
        trk_armed  = 1'b0;
        expect_action(ACT_STOPPED, w.t);
      end
      return;
    end
    if (trk_forced) begin
      trk_forced   = 1'b0;
      trk_deadline = expiry_of(w.t);
      trk_armed    = 1'b1;
      expect_action(ACT_PROX_IN, w.t);
    end
  endtask

  // driver: bursts of words from the backlog with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      evt_bus.valid         <= 1'b0;
      evt_bus.operation     <= 1'b0;
      evt_bus.time_us       <= '0;
      evt_bus.event_kind    <= '0;
      evt_bus.button_index  <= '0;
      evt_bus.event_value   <= '0;
      evt_bus.last_in_frame <= 1'b0;
      gap_left              <= 0;
      burst_left            <= 0;
    end else begin
      if (evt_bus.valid && evt_bus.ready) track_word(live_word);
      if (!evt_bus.valid || evt_bus.ready) begin
        if (gap_left != 0) begin
          evt_bus.valid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (evt_backlog.size() != 0) begin
          next_word = evt_backlog.pop_front();
          live_word               <= next_word;
          evt_bus.valid           <= 1'b1;
          evt_bus.operation       <= next_word.op;
          evt_bus.time_us         <= next_word.t;
          evt_bus.event_kind      <= next_word.kind;
          evt_bus.button_index    <= next_word.bidx;
          evt_bus.event_value     <= next_word.val;
          evt_bus.last_in_frame   <= next_word.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          evt_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall window at the start of each round of the 5-bit stall counter
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      stall_cnt     <= '0;
      stall_len     <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1'b1;
      if (stall_cnt == '0)
        stall_len <= (res_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      res_bus.ready <= !res_hold && (int'(stall_cnt) >= stall_len);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (due_actions.size() == 0) begin
        flag_mismatch($sformatf("unexpected word action %0d time %0d",
                                res_bus.action, res_bus.action_time_us));
      end else begin
        got_word = due_actions.pop_front();
        if (res_bus.action !== got_word.act)
          flag_mismatch($sformatf("action %0d, expected %0d",
                                  res_bus.action, got_word.act));
        if (res_bus.action_time_us !== got_word.ts)
          flag_mismatch($sformatf("action_time_us %0d, expected %0d",
                                  res_bus.action_time_us, got_word.ts));
      end
    end
  end

  // long receiver hold-off so the input queue fills
  initial begin
    wait (press_go);
    @(posedge clk);
    res_hold <= 1'b1;
    repeat (300) @(posedge clk);
    res_hold <= 1'b0;
  end

  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_word(input op_t op, input logic [TIME_BITS-1:0] t, input kind_t kind,
                           input logic [1:0] bidx, input value_t val, input logic last);
    evt_word_t w;
    w.op   = op;
    w.t    = t;
    w.kind = kind;
    w.bidx = bidx;
    w.val  = val;
    w.last = last;
    evt_backlog.push_back(w);
  endtask

  task automatic drain();
    while (evt_backlog.size() != 0 || evt_bus.valid || due_actions.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_BITS-1:0] v);
    @(posedge clk);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.timeout_us <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    trk_timeout = v;
  endtask

  // frames of 1..4 events on a running clock, timer checks and some noise;
  // the last pen event of a frame is always a press so tracking survives
  task automatic queue_random(input int count, input int unsigned to);
    int                   made;
    int                   pick;
    int                   n;
    int                   last_pen;
    kind_t                ks[4];
    value_t               v;
    logic [TIME_BITS-1:0] tc;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        tc = TIME_BITS'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 0)
          push_word(OP_CHECK, tc, kind_t'($urandom_range(0, 2)), 2'($urandom_range(0, 3)),
                    value_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 2) == 0)
          push_word(OP_EVENT, tc, KIND_PEN, 2'($urandom_range(0, 3)), VAL_PRESS,
                    1'($urandom_range(0, 1)));
        else
          push_word(OP_EVENT, tc, kind_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    value_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        made++;
      end else if (pick < 30) begin
        tc = clock_us + TIME_BITS'($urandom_range(0, 3 * to));
        if ($urandom_range(0, 1) == 1) clock_us = tc;
        push_word(OP_CHECK, tc, kind_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  value_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        clock_us = clock_us + TIME_BITS'($urandom_range(0, 2 * to));
        n = $urandom_range(1, 4);
        last_pen = -1;
        for (int j = 0; j < n; j++) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) ks[j] = KIND_OTHER;
          else if (pick < 7) ks[j] = KIND_BUTTON;
          else begin
            ks[j] = KIND_PEN;
            last_pen = j;
          end
        end
        for (int j = 0; j < n; j++) begin
          if (ks[j] == KIND_BUTTON)
            v = ($urandom_range(0, 9) < 6) ? VAL_RELEASE : value_t'($urandom_range(1, 2));
          else if (j == last_pen)
            v = VAL_PRESS;
          else
            v = value_t'($urandom_range(0, 2));
          push_word(OP_EVENT, clock_us, ks[j], 2'($urandom_range(0, 3)), v, j == n - 1);
          if (j < n - 1 && $urandom_range(0, 9) == 0) begin
            push_word(OP_CHECK, clock_us + TIME_BITS'($urandom_range(0, 2 * to)), KIND_OTHER,
                      2'($urandom_range(0, 3)), VAL_RELEASE, 1'($urandom_range(0, 1)));
            made++;
          end
        end
        made += n;
      end
    end
  endtask

  initial begin
    int unsigned to;
    int          stop_sel;
    cfg_bus.valid         = 1'b0;
    cfg_bus.timeout_us    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: first events at time zero, deadline edges, floor at zero, saturation
    write_timeout(TIMEOUT_BITS'(1));
    gap_max = 3;
    push_word(OP_CHECK, 48'd0, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd0, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b1);
    push_word(OP_EVENT, 48'd0, KIND_OTHER, 2'd3, VAL_REPEAT, 1'b1);
    drain();
    write_timeout(TIMEOUT_BITS'(1000000));
    push_word(OP_CHECK, 48'd1, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd100, KIND_BUTTON, 2'd3, VAL_REPEAT, 1'b0);
    push_word(OP_CHECK, 48'd2000000, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd100, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b1);
    push_word(OP_CHECK, 48'd3000000, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd3000000, KIND_BUTTON, 2'd3, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd3000000, KIND_PEN, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd3000000, KIND_PEN, 2'd0, VAL_REPEAT, 1'b0);
    push_word(OP_EVENT, 48'd3000000, KIND_PEN, 2'd0, VAL_PRESS, 1'b1);
    push_word(OP_CHECK, 48'd3999999, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_CHECK, 48'd4000000, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd5000000, KIND_BUTTON, 2'd1, VAL_PRESS, 1'b0);
    push_word(OP_EVENT, 48'd5000000, KIND_BUTTON, 2'd1, VAL_RELEASE, 1'b1);
    push_word(OP_EVENT, 48'd5900000, KIND_OTHER, 2'd2, VAL_PRESS, 1'b0);
    push_word(OP_CHECK, 48'd6000000, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, 48'd5900000, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b1);
    push_word(OP_CHECK, 48'd6900000, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b1);
    push_word(OP_EVENT, TIME_MAX - 48'd5, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b1);
    push_word(OP_CHECK, TIME_MAX - 48'd1, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_CHECK, TIME_MAX, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    drain();

    clock_us = 48'd10000000;
    to = $urandom_range(1, 300);
    write_timeout(TIMEOUT_BITS'(to));
    gap_max = 6;
    queue_random(350, to);
    drain();

    to = 1;
    write_timeout(TIMEOUT_BITS'(to));
    gap_max = 0;
    res_steady = 1'b1;
    queue_random(250, to);
    drain();

    to = 1000000;
    write_timeout(TIMEOUT_BITS'(to));
    gap_max = 10;
    res_steady = 1'b0;
    queue_random(250, to);
    drain();

    // back-to-back out/in pairs while the receiver holds off
    to = $urandom_range(1, 1000);
    write_timeout(TIMEOUT_BITS'(to));
    gap_max = 0;
    press_go = 1'b1;
    for (int b = 0; b < 4; b++)
      push_word(OP_EVENT, clock_us, KIND_BUTTON, 2'(b), VAL_RELEASE, b == 3);
    push_word(OP_EVENT, clock_us, KIND_PEN, 2'd0, VAL_PRESS, 1'b1);
    repeat (100) begin
      clock_us = clock_us + TIME_BITS'(to);
      push_word(OP_CHECK, clock_us, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
      clock_us = clock_us + 48'd1;
      push_word(OP_EVENT, clock_us, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b1);
    end
    drain();

    to = 50000;
    write_timeout(TIMEOUT_BITS'(to));
    gap_max = 5;
    queue_random(300, to);
    drain();

    to = $urandom_range(1, 1000000);
    write_timeout(TIMEOUT_BITS'(to));
    gap_max = 4;
    queue_random(300, to);
    drain();

    // tracking stops for good; everything after it is ignored
    stop_sel = $urandom_range(0, 2);
    clock_us = clock_us + 48'd7;
    if (stop_sel == 0)
      push_word(OP_EVENT, clock_us, KIND_OTHER_TOOL, 2'd2, VAL_PRESS, 1'($urandom_range(0, 1)));
    else if (stop_sel == 1)
      push_word(OP_EVENT, clock_us, KIND_PEN, 2'd0, VAL_RELEASE, 1'b1);
    else
      push_word(OP_EVENT, clock_us, KIND_PEN, 2'd0, VAL_REPEAT, 1'b1);
    push_word(OP_EVENT, clock_us + 48'd1, KIND_OTHER_TOOL, 2'd1, VAL_RELEASE, 1'b1);
    push_word(OP_CHECK, TIME_MAX, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    push_word(OP_EVENT, clock_us + 48'd2, KIND_PEN, 2'd0, VAL_PRESS, 1'b1);
    push_word(OP_EVENT, clock_us + 48'd3, KIND_BUTTON, 2'd2, VAL_PRESS, 1'b1);
    push_word(OP_EVENT, clock_us + 48'd4, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b1);
    push_word(OP_CHECK, clock_us + 48'd5000000, KIND_OTHER, 2'd0, VAL_RELEASE, 1'b0);
    drain();
    repeat (20) @(posedge clk);

    if (err_count == 0 && due_actions.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
